// ===== rtl/decimal_add_subtract_assert.svh =====
// ----------------------------------------------------------------------------
// Decimal add/subtract assertion macros
// Concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_ADD_SUBTRACT_ASSERT_SVH
`define DECIMAL_ADD_SUBTRACT_ASSERT_SVH

// hold cons in the same cycle as ante
`define DAS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// hold cons in the cycle after ante
`define DAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/das_pkg.sv =====
// ----------------------------------------------------------------------------
// das_pkg
// Item types, constants and helpers shared by the decimal add/subtract unit.
// ----------------------------------------------------------------------------
package das_pkg;

   localparam logic       OP_ADD    = 1'b0;
   localparam logic       OP_SUB    = 1'b1;
   localparam logic [3:0] DIGIT_MAX = 4'd9;
   localparam logic [3:0] DIGIT_ONE = 4'd1;
   localparam logic [4:0] RADIX     = 5'd10;

   typedef struct packed {
      logic       op;
      logic [3:0] digit_a;
      logic [3:0] digit_b;
      logic       last_pair;
   } req_type;

   typedef struct packed {
      logic [3:0] result_digit;
      logic       negative;
      logic       last_digit;
      logic       overflow;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic shift;
   } store_ctrl_type;

   typedef struct packed {
      logic clear;
      logic step;
      logic pop;
   } res_ctrl_type;

   function automatic logic [3:0] clamp_digit(input logic [3:0] d);
      clamp_digit = (d > DIGIT_MAX) ? DIGIT_MAX : d;
   endfunction

endpackage

// ===== rtl/das_operand_store.sv =====
// ----------------------------------------------------------------------------
// das_operand_store
// Operand digit shift registers: load most significant first, unload least
// significant first.
// ----------------------------------------------------------------------------
module das_operand_store #(
   parameter int NUM_DIGITS = 8
) (
   input  logic                     clock,
   input  das_pkg::store_ctrl_type  ctrl,
   input  logic [3:0]               load_a,
   input  logic [3:0]               load_b,
   output logic [3:0]               lsd_a,
   output logic [3:0]               lsd_b
);

   localparam int W = 4 * NUM_DIGITS;

   logic [W-1:0] sa_ff, sa_in;
   logic [W-1:0] sb_ff, sb_in;

   always_comb begin
      sa_in = sa_ff;
      sb_in = sb_ff;
      if (ctrl.load) begin
         sa_in = (sa_ff << 4) | W'(das_pkg::clamp_digit(load_a));
         sb_in = (sb_ff << 4) | W'(das_pkg::clamp_digit(load_b));
      end else if (ctrl.shift) begin
         sa_in = sa_ff >> 4;
         sb_in = sb_ff >> 4;
      end
   end

   always_ff @(posedge clock) begin
      sa_ff <= sa_in;
      sb_ff <= sb_in;
   end

   assign lsd_a = sa_ff[3:0];
   assign lsd_b = sb_ff[3:0];

endmodule

// ===== rtl/das_result_store.sv =====
// ----------------------------------------------------------------------------
// das_result_store
// Serial decimal digit unit with carry/borrow registers and result shift
// registers; forms a+b or a-b and b-a together, one digit a cycle.
// ----------------------------------------------------------------------------
module das_result_store #(
   parameter int NUM_DIGITS = 8
) (
   input  logic                   clock,
   input  das_pkg::res_ctrl_type  ctrl,
   input  logic                   op_sub,
   input  logic [3:0]             digit_a,
   input  logic [3:0]             digit_b,
   output logic [3:0]             msd,
   output logic                   carry
);

   localparam int W = 4 * NUM_DIGITS;

   logic [W-1:0] r1_ff, r1_in;
   logic [W-1:0] r2_ff, r2_in;
   logic         c1_ff, c1_in;
   logic         c2_ff, c2_in;
   logic [4:0]   sum;
   logic [4:0]   ya;
   logic [4:0]   yb;
   logic [4:0]   dab;
   logic [4:0]   dba;
   logic         bab;
   logic         bba;
   logic [3:0]   d1;

   always_comb begin
      sum = {1'b0, digit_a} + {1'b0, digit_b} + {4'b0, c1_ff};
      ya  = {1'b0, digit_b} + {4'b0, c1_ff};
      yb  = {1'b0, digit_a} + {4'b0, c2_ff};
      bab = {1'b0, digit_a} < ya;
      bba = {1'b0, digit_b} < yb;
      dab = bab ? ({1'b0, digit_a} + das_pkg::RADIX - ya) : ({1'b0, digit_a} - ya);
      dba = bba ? ({1'b0, digit_b} + das_pkg::RADIX - yb) : ({1'b0, digit_b} - yb);
      if (op_sub) begin
         d1    = dab[3:0];
         c1_in = bab;
      end else if (sum >= das_pkg::RADIX) begin
         d1    = 4'(sum - das_pkg::RADIX);
         c1_in = 1'b1;
      end else begin
         d1    = sum[3:0];
         c1_in = 1'b0;
      end
      c2_in = bba;
      r1_in = r1_ff;
      r2_in = r2_ff;
      if (ctrl.step) begin
         r1_in = (r1_ff << 4) | W'(d1);
         r2_in = (r2_ff << 4) | W'(dba[3:0]);
      end else if (ctrl.pop) begin
         r1_in = r1_ff >> 4;
         r2_in = r2_ff >> 4;
      end
   end

   always_ff @(posedge clock) begin
      r1_ff <= r1_in;
      r2_ff <= r2_in;
      if (ctrl.clear) begin
         c1_ff <= 1'b0;
         c2_ff <= 1'b0;
      end else if (ctrl.step) begin
         c1_ff <= c1_in;
         c2_ff <= c2_in;
      end
   end

   assign msd   = (op_sub && c1_ff) ? r2_ff[3:0] : r1_ff[3:0];
   assign carry = c1_ff;

endmodule

// ===== rtl/decimal_add_subtract.sv =====
// ----------------------------------------------------------------------------
// decimal_add_subtract
// Adds or subtracts two unsigned decimal numbers given as digit pairs and
// returns the result digits, most significant first.
//
//   Port group   Direction   Moves
//   req_*        in          one digit pair with op and last_pair
//   rsp_*        out         one result digit with sign, last and overflow
//
// Pairs are loaded while req_stall is low. After the last pair the serial
// digit unit walks the n stored digits, one a cycle; then the leading zeros
// of a difference are stripped; digits go out one a cycle unless stalled.
// req_stall is high from the last pair until the last result digit is
// registered; rsp_stall holds the output register and delays the next digit.
// Reset is synchronous and clears the control state only.
// ----------------------------------------------------------------------------
`include "decimal_add_subtract_assert.svh"

module decimal_add_subtract #(
   parameter int NUM_DIGITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  das_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output das_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(NUM_DIGITS + 1);

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    step_ff, step_in;
   logic             op_ff, op_in;
   logic             ovf_ff, ovf_in;
   logic             lead_done_ff, lead_done_in;
   logic             strip_ff, strip_in;
   logic             rsp_valid_ff, rsp_valid_in;
   das_pkg::rsp_type rsp_data_ff, rsp_data_in;

   das_pkg::store_ctrl_type store_ctrl;
   das_pkg::res_ctrl_type   res_ctrl;
   logic [3:0]              lsd_a;
   logic [3:0]              lsd_b;
   logic [3:0]              msd;
   logic                    carry;
   logic                    req_fire;
   logic                    out_free;
   logic                    emit_last;

   das_operand_store #(
      .NUM_DIGITS(NUM_DIGITS)
   ) u_operands (
      .clock  (clock),
      .ctrl   (store_ctrl),
      .load_a (req_data.digit_a),
      .load_b (req_data.digit_b),
      .lsd_a  (lsd_a),
      .lsd_b  (lsd_b)
   );

   das_result_store #(
      .NUM_DIGITS(NUM_DIGITS)
   ) u_result (
      .clock   (clock),
      .ctrl    (res_ctrl),
      .op_sub  (op_ff == das_pkg::OP_SUB),
      .digit_a (lsd_a),
      .digit_b (lsd_b),
      .msd     (msd),
      .carry   (carry)
   );

   assign req_stall = (state_ff != ST_LOAD);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      op_in        = op_ff;
      ovf_in       = ovf_ff;
      lead_done_in = lead_done_ff;
      strip_in     = strip_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      store_ctrl   = '0;
      res_ctrl     = '0;
      emit_last    = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (count_ff == '0 && !ovf_ff) begin
                  op_in = req_data.op;
               end
               if (count_ff < CW'(NUM_DIGITS)) begin
                  store_ctrl.load = 1'b1;
                  count_in        = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_pair) begin
                  res_ctrl.clear = 1'b1;
                  step_in        = '0;
                  state_in       = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            store_ctrl.shift = 1'b1;
            res_ctrl.step    = 1'b1;
            step_in          = step_ff + 1'b1;
            if (CW'(step_ff + 1'b1) == count_ff) begin
               lead_done_in = 1'b0;
               strip_in     = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (op_ff == das_pkg::OP_ADD && carry && !lead_done_ff) begin
               if (out_free) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.result_digit = das_pkg::DIGIT_ONE;
                  rsp_data_in.negative     = 1'b0;
                  rsp_data_in.last_digit   = 1'b0;
                  rsp_data_in.overflow     = ovf_ff;
                  lead_done_in             = 1'b1;
               end
            end else if (op_ff == das_pkg::OP_SUB && strip_ff && msd == '0
                         && count_ff > CW'(1)) begin
               // drop a leading zero
               res_ctrl.pop = 1'b1;
               count_in     = count_ff - 1'b1;
            end else if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.result_digit = msd;
               rsp_data_in.negative     = (op_ff == das_pkg::OP_SUB) && carry;
               rsp_data_in.last_digit   = (count_ff == CW'(1));
               rsp_data_in.overflow     = ovf_ff;
               res_ctrl.pop             = 1'b1;
               strip_in                 = 1'b0;
               count_in                 = count_ff - 1'b1;
               if (count_ff == CW'(1)) begin
                  emit_last = 1'b1;
                  op_in     = das_pkg::OP_ADD;
                  ovf_in    = 1'b0;
                  state_in  = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         step_ff      <= '0;
         op_ff        <= das_pkg::OP_ADD;
         ovf_ff       <= 1'b0;
         lead_done_ff <= 1'b0;
         strip_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         op_ff        <= op_in;
         ovf_ff       <= ovf_in;
         lead_done_ff <= lead_done_in;
         strip_ff     <= strip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `DAS_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= CW'(NUM_DIGITS), "digit count beyond capacity")
   `DAS_ASSERT_SAME(a_emit_nonempty, clock, reset, state_ff == ST_EMIT, count_ff != '0, "emitting with no digits left")
   `DAS_ASSERT_SAME(a_digit_decimal, clock, reset, rsp_valid_ff, rsp_data_ff.result_digit <= das_pkg::DIGIT_MAX, "result digit above nine")
   `DAS_ASSERT_NEXT(a_last_to_load, clock, reset, emit_last, state_ff == ST_LOAD && count_ff == '0 && rsp_data_ff.last_digit, "last digit did not return to loading")

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the decimal add/subtract unit. Digit pairs are
// fed through the request channel while a local predictor builds the result
// digits each number should give; every result digit is compared field by
// field, in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

   localparam int NUM_DIGITS = 8;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   das_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   das_pkg::rsp_type rsp_data;

   logic       calm = 1'b0;
   int         gap_percent = 20;
   int         stall_percent = 15;
   int         stall_left = 0;
   int         stall_phase = 0;

   logic [3:0] num_a [NUM_DIGITS];
   logic [3:0] num_b [NUM_DIGITS];
   int         pair_count = 0;
   logic       held_op = das_pkg::OP_ADD;
   logic       dropped = 1'b0;

   das_pkg::rsp_type pending_digits [$];
   int         mismatches = 0;
   int         pairs_taken = 0;
   int         digits_checked = 0;
   int         sums_done = 0;
   int         differences_done = 0;
   int         negatives_seen = 0;
   int         overflows_seen = 0;
   int         idle_cycles = 0;

   decimal_add_subtract #(
      .NUM_DIGITS(NUM_DIGITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void put_digit(input logic [3:0] value, input logic neg,
                                     input logic final_digit);
      das_pkg::rsp_type item;
      item.result_digit = value;
      item.negative     = neg;
      item.last_digit   = final_digit;
      item.overflow     = dropped;
      pending_digits.push_back(item);
   endfunction

   function automatic void take_pair(input das_pkg::req_type pair);
      logic [3:0] da, db;
      logic [3:0] digits [NUM_DIGITS];
      logic [3:0] top [NUM_DIGITS];
      logic [3:0] bottom [NUM_DIGITS];
      int         n, s, carry, first;
      logic       neg;
      da = (pair.digit_a > das_pkg::DIGIT_MAX) ? das_pkg::DIGIT_MAX : pair.digit_a;
      db = (pair.digit_b > das_pkg::DIGIT_MAX) ? das_pkg::DIGIT_MAX : pair.digit_b;
      if (pair_count == 0 && !dropped) held_op = pair.op;
      if (pair_count < NUM_DIGITS) begin
         num_a[pair_count] = da;
         num_b[pair_count] = db;
         pair_count++;
      end else begin
         dropped = 1'b1;
      end
      if (!pair.last_pair) return;
      n     = pair_count;
      neg   = 1'b0;
      carry = 0;
      if (dropped) overflows_seen++;
      if (held_op == das_pkg::OP_ADD) begin
         for (int i = n - 1; i >= 0; i--) begin
            s       = int'(num_a[i]) + int'(num_b[i]) + carry;
            carry   = (s >= int'(das_pkg::RADIX)) ? 1 : 0;
            digits[i] = 4'(s - int'(das_pkg::RADIX) * carry);
         end
         if (carry != 0) put_digit(das_pkg::DIGIT_ONE, 1'b0, 1'b0);
         for (int i = 0; i < n; i++) put_digit(digits[i], 1'b0, i == n - 1);
         sums_done++;
      end else begin
         top    = num_a;
         bottom = num_b;
         for (int i = 0; i < n; i++) begin
            if (num_a[i] != num_b[i]) begin
               if (num_a[i] < num_b[i]) begin
                  top    = num_b;
                  bottom = num_a;
                  neg    = 1'b1;
               end
               break;
            end
         end
         for (int i = n - 1; i >= 0; i--) begin
            s       = int'(top[i]) - int'(bottom[i]) - carry;
            carry   = (s < 0) ? 1 : 0;
            digits[i] = 4'(s + int'(das_pkg::RADIX) * carry);
         end
         first = 0;
         while (first + 1 < n && digits[first] == 4'd0) first++;
         for (int i = first; i < n; i++) put_digit(digits[i], neg, i == n - 1);
         differences_done++;
         if (neg) negatives_seen++;
      end
      pair_count = 0;
      held_op    = das_pkg::OP_ADD;
      dropped    = 1'b0;
   endfunction

   function automatic void compare_field(input string name, input logic [3:0] want,
                                         input logic [3:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      das_pkg::rsp_type want;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            idle_cycles = 0;
            pairs_taken++;
            take_pair(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            digits_checked++;
            if (pending_digits.size() == 0) begin
               $display("%0t: unexpected result digit, expected none, actual %p",
                        $time, rsp_data);
               mismatches++;
            end else begin
               want = pending_digits.pop_front();
               compare_field("result_digit", want.result_digit, rsp_data.result_digit);
               compare_field("negative", 4'(want.negative), 4'(rsp_data.negative));
               compare_field("last_digit", 4'(want.last_digit), 4'(rsp_data.last_digit));
               compare_field("overflow", 4'(want.overflow), 4'(rsp_data.overflow));
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d result digits outstanding",
                     $time, IDLE_LIMIT, pending_digits.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0) stall_percent <= 15 * $urandom_range(0, 2);
      if (reset || calm) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_percent) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_pair(input das_pkg::req_type pair);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < gap_percent) gap = $urandom_range(1, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pair;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_number(input logic op, input logic [3:0] a_q [$],
                              input logic [3:0] b_q [$]);
      das_pkg::req_type pair;
      for (int k = 0; k < a_q.size(); k++) begin
         pair.op        = (k == 0) ? op : 1'($urandom_range(0, 1));
         pair.digit_a   = a_q[k];
         pair.digit_b   = b_q[k];
         pair.last_pair = (k == a_q.size() - 1);
         send_pair(pair);
      end
   endtask

   function automatic logic [3:0] pick_digit();
      if ($urandom_range(0, 19) == 0) return 4'($urandom_range(10, 15));
      return 4'($urandom_range(0, 9));
   endfunction

   task automatic test_add_extremes();
      logic [3:0] a_q [$];
      logic [3:0] b_q [$];
      for (int k = 0; k < NUM_DIGITS; k++) begin
         a_q.push_back(das_pkg::DIGIT_MAX);
         b_q.push_back(das_pkg::DIGIT_MAX);
      end
      send_number(das_pkg::OP_ADD, a_q, b_q);
      a_q = '{4'd0};
      b_q = '{4'd0};
      send_number(das_pkg::OP_ADD, a_q, b_q);
   endtask

   task automatic test_subtract_cases();
      logic [3:0] a_q [$];
      logic [3:0] b_q [$];
      a_q = '{4'd5};
      b_q = '{4'd5};
      send_number(das_pkg::OP_SUB, a_q, b_q);
      a_q = '{4'd1, 4'd0, 4'd0};
      b_q = '{4'd1, 4'd0, 4'd1};
      send_number(das_pkg::OP_SUB, a_q, b_q);
   endtask

   task automatic test_clamped_digits();
      logic [3:0] a_q [$];
      logic [3:0] b_q [$];
      a_q = '{4'd15, 4'd12};
      b_q = '{4'd10, 4'd13};
      send_number(das_pkg::OP_ADD, a_q, b_q);
   endtask

   task automatic test_dropped_pairs();
      logic [3:0] a_q [$];
      logic [3:0] b_q [$];
      for (int k = 0; k < NUM_DIGITS + 2; k++) begin
         a_q.push_back(4'($urandom_range(0, 9)));
         b_q.push_back(4'($urandom_range(0, 9)));
      end
      send_number(das_pkg::OP_SUB, a_q, b_q);
   endtask

   task automatic test_random_numbers(input int budget);
      logic [3:0] a_q [$];
      logic [3:0] b_q [$];
      logic [3:0] d;
      int         sent, len, r;
      logic       shared;
      sent = 0;
      while (sent < budget) begin
         if (budget - sent <= 40) calm <= 1'b1;
         r = $urandom_range(0, 99);
         if (r < 6) len = $urandom_range(NUM_DIGITS + 1, NUM_DIGITS + 3);
         else if (r < 16) len = NUM_DIGITS;
         else len = $urandom_range(1, NUM_DIGITS - 1);
         shared = ($urandom_range(0, 2) == 0);
         a_q.delete();
         b_q.delete();
         for (int k = 0; k < len; k++) begin
            d = pick_digit();
            a_q.push_back(d);
            b_q.push_back((shared && $urandom_range(0, 5) != 0) ? d : pick_digit());
         end
         gap_percent = 15 * $urandom_range(0, 2);
         send_number(1'($urandom_range(0, 1)), a_q, b_q);
         sent += len;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_add_extremes();
      test_subtract_cases();
      test_clamped_digits();
      test_dropped_pairs();
      test_random_numbers(285);
      req_valid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Fed %0d digit pairs: %0d sums, %0d differences (%0d negative), %0d overflowed",
               pairs_taken, sums_done, differences_done, negatives_seen, overflows_seen);
      $display("Checked %0d result digits, %0d mismatches", digits_checked, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
